[rtl/sus_pkg.sv]
package sus_pkg;

  // Storage depth and key width
  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned VALUE_WIDTH = 32;

  // Fixed field widths of the request and result transfers
  localparam int unsigned REQ_VALUE_W = 32;
  localparam int unsigned COUNT_W     = 5;

  // Internal occupancy counter, wide enough to hold CAPACITY itself
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic                          operation;
    logic signed [REQ_VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic               success;
    logic               full_reject;
    logic [COUNT_W-1:0] count;
  } rsp_t;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic cmp_en;  // latch compare flags against the incoming key
    logic ins_en;  // shift up and drop the key in at its sorted slot
    logic rem_en;  // shift down over the matching slot
  } cell_ctl_t;

endpackage

[rtl/sus_cell.sv]
module sus_cell (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  sus_pkg::cell_ctl_t                    ctl_i,
  input  logic signed [sus_pkg::VALUE_WIDTH-1:0] cmp_key_i,
  input  logic signed [sus_pkg::VALUE_WIDTH-1:0] key_i,
  input  logic                                  occupied_i,
  input  logic                                  left_below_i,
  input  logic signed [sus_pkg::VALUE_WIDTH-1:0] left_value_i,
  input  logic signed [sus_pkg::VALUE_WIDTH-1:0] right_value_i,
  output logic signed [sus_pkg::VALUE_WIDTH-1:0] value_o,
  output logic                                  below_o,
  output logic                                  equal_o
);

  logic signed [sus_pkg::VALUE_WIDTH-1:0] value_q, value_d;
  logic below_q, equal_q;

  // Flags: this slot holds a stored value that is below / equal to the key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      below_q <= 1'b0;
      equal_q <= 1'b0;
    end else if (ctl_i.cmp_en) begin
      below_q <= occupied_i && (value_q < cmp_key_i);
      equal_q <= occupied_i && (value_q == cmp_key_i);
    end
  end

  // Slots below the key keep their value; the first one at or above the key
  // takes the key on insert, the rest take from the left (insert) or right (remove).
  always_comb begin
    value_d = value_q;
    if (ctl_i.ins_en && !below_q) begin
      value_d = left_below_i ? key_i : left_value_i;
    end else if (ctl_i.rem_en && !below_q) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign below_o = below_q;
  assign equal_o = equal_q;

endmodule

[rtl/sorted_unique_set_core.sv]
// Channel   Ports                    Direction  Transfer when
// request   start_i, req_i, busy_o   in         start_i high and busy_o low
// result    done_o, rsp_o            out        every cycle done_o is high
//
// Each request has a compare step and a shift step: on the accepting edge every
// cell compares its stored value with the key and latches below/equal flags;
// on the next edge the chain shifts by one slot and the result is registered.
// done_o shows the result in the cycle after that, while the next request may
// be taken. busy_o is high for the one compare-to-shift cycle.
// Reset clears the count and control; cell contents are garbage until written.
// The result side cannot stall: done_o marks each result for exactly one cycle.
module sorted_unique_set_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  sus_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output sus_pkg::rsp_t rsp_o
);

  localparam int unsigned N = sus_pkg::CAPACITY;

  logic                                    busy_q;
  logic                                    op_q;
  logic signed [sus_pkg::VALUE_WIDTH-1:0]   key_q;
  logic signed [sus_pkg::VALUE_WIDTH-1:0]   cmp_key;
  logic [sus_pkg::CNT_W-1:0]               count_q, count_d;
  logic                                    done_q;
  sus_pkg::rsp_t                           rsp_q, rsp_d;
  sus_pkg::cell_ctl_t                      ctl;

  logic                                    accept;
  logic                                    present;
  logic                                    full;

  logic [N-1:0]                            occupied;
  logic [N-1:0]                            below;
  logic [N-1:0]                            equal;
  logic signed [sus_pkg::VALUE_WIDTH-1:0]   cell_value [N];

  assign accept  = start_i && !busy_q;
  // request key cast to VALUE_WIDTH bits (both widths are 32, so it is unchanged)
  assign cmp_key = sus_pkg::VALUE_WIDTH'(req_i.value);

  // Cells at or above the count hold nothing readable
  for (genvar i = 0; i < N; i++) begin : g_occ
    assign occupied[i] = count_q > sus_pkg::CNT_W'(i);
  end

  assign present = |equal;
  assign full    = count_q == sus_pkg::CNT_W'(N);

  always_comb begin
    ctl.cmp_en = accept;
    ctl.ins_en = busy_q && (op_q == sus_pkg::OP_INSERT) && !present && !full;
    ctl.rem_en = busy_q && (op_q == sus_pkg::OP_REMOVE) && present;
  end

  // Chain of compare-and-shift cells. Cell 0 sees a "below" left neighbor so
  // it takes the key when the key is the new minimum; the last cell takes its
  // own value on remove (that slot drops out of the count anyway).
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                                  left_below;
    logic signed [sus_pkg::VALUE_WIDTH-1:0] left_value;
    logic signed [sus_pkg::VALUE_WIDTH-1:0] right_value;

    if (i == 0) begin : g_first
      assign left_below = 1'b1;
      assign left_value = key_q;
    end else begin : g_mid
      assign left_below = below[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_value = cell_value[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    sus_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .cmp_key_i     (cmp_key),
      .key_i         (key_q),
      .occupied_i    (occupied[i]),
      .left_below_i  (left_below),
      .left_value_i  (left_value),
      .right_value_i (right_value),
      .value_o       (cell_value[i]),
      .below_o       (below[i]),
      .equal_o       (equal[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctl.ins_en) begin
      count_d = count_q + sus_pkg::CNT_W'(1);
    end else if (ctl.rem_en) begin
      count_d = count_q - sus_pkg::CNT_W'(1);
    end
    rsp_d.success     = ctl.ins_en || ctl.rem_en;
    rsp_d.full_reject = (op_q == sus_pkg::OP_INSERT) && !present && full;
    rsp_d.count       = sus_pkg::COUNT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      busy_q  <= accept;
      done_q  <= busy_q;
      count_q <= count_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= cmp_key;
      op_q  <= req_i.operation;
    end
    if (busy_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

[rtl/sus_checker.sv]
module sus_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input sus_pkg::req_t req_i,
  input logic          busy_o,
  input logic          done_o,
  input sus_pkg::rsp_t rsp_o
);

  // every accepted request is followed by a result on done_o
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("result missing after accepted request");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result without a request in flight");

  a_busy_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o)
    else $error("busy held longer than one cycle");

  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.full_reject) |->
      (!rsp_o.success && rsp_o.count == sus_pkg::COUNT_W'(sus_pkg::CAPACITY)))
    else $error("full reject with inconsistent success or count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.count <= sus_pkg::COUNT_W'(sus_pkg::CAPACITY)))
    else $error("count above capacity");

endmodule

bind sorted_unique_set_core sus_checker u_sus_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .req_i   (req_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .rsp_o   (rsp_o)
);
